FILE: hw/rtl/nws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nws_pkg - shared types and constants of the neuron evaluator
// Widths of the Q4.12 datapath, the queue entry and final-sum structs and
// the sigmoid lookup table.
// ----------------------------------------------------------------------------
package nws_pkg;

  localparam int VAL_W           = 16;  // Q4.12 operand
  localparam int PROD_W          = 32;  // Q8.24 product
  localparam int ACC_W           = 40;  // accumulator
  localparam int SIG_IDX_W       = 8;   // table index
  localparam int SIG_W           = 12;  // table entry
  localparam int SIG_SLOTS       = 256;
  localparam int FRAC_W          = 12;
  localparam int NWS_QUEUE_DEPTH = 4;

  // one product waiting between front and back
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic                     last;
  } q_entry_t;

  // finished neuron, both output paths
  typedef struct packed {
    logic signed [ACC_W-1:0]  sum;
    logic signed [PROD_W-1:0] first;
  } fin_t;

  // round(4096 / (1 + exp(-(k - 128) / 16)))
  localparam logic [SIG_W-1:0] SIG_TABLE [SIG_SLOTS] = '{
    12'd1, 12'd1, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2,
    12'd3, 12'd3, 12'd3, 12'd3, 12'd3, 12'd4, 12'd4, 12'd4, 12'd4, 12'd5,
    12'd5, 12'd5, 12'd5, 12'd6, 12'd6, 12'd7, 12'd7, 12'd7, 12'd8, 12'd8,
    12'd9, 12'd10, 12'd10, 12'd11, 12'd11, 12'd12, 12'd13, 12'd14, 12'd15, 12'd16,
    12'd17, 12'd18, 12'd19, 12'd20, 12'd21, 12'd23, 12'd24, 12'd26, 12'd27, 12'd29,
    12'd31, 12'd33, 12'd35, 12'd37, 12'd40, 12'd42, 12'd45, 12'd48, 12'd51, 12'd54,
    12'd58, 12'd61, 12'd65, 12'd69, 12'd74, 12'd78, 12'd83, 12'd89, 12'd94, 12'd100,
    12'd106, 12'd113, 12'd120, 12'd128, 12'd136, 12'd144, 12'd153, 12'd162, 12'd172,
    12'd183,
    12'd194, 12'd206, 12'd219, 12'd232, 12'd246, 12'd261, 12'd277, 12'd293, 12'd311,
    12'd329,
    12'd349, 12'd369, 12'd391, 12'd413, 12'd437, 12'd462, 12'd488, 12'd516, 12'd545,
    12'd575,
    12'd606, 12'd639, 12'd674, 12'd710, 12'd747, 12'd786, 12'd827, 12'd869, 12'd912,
    12'd957,
    12'd1004, 12'd1052, 12'd1102, 12'd1153, 12'd1205, 12'd1259, 12'd1314, 12'd1370,
    12'd1428, 12'd1487,
    12'd1546, 12'd1607, 12'd1668, 12'd1731, 12'd1793, 12'd1857, 12'd1920, 12'd1984,
    12'd2048,
    12'd2112, 12'd2176, 12'd2239, 12'd2303, 12'd2365, 12'd2428, 12'd2489, 12'd2550,
    12'd2609, 12'd2668, 12'd2726, 12'd2782, 12'd2837, 12'd2891, 12'd2943, 12'd2994,
    12'd3044, 12'd3092,
    12'd3139, 12'd3184, 12'd3227, 12'd3269, 12'd3310, 12'd3349, 12'd3386, 12'd3422,
    12'd3457, 12'd3490,
    12'd3521, 12'd3551, 12'd3580, 12'd3608, 12'd3634, 12'd3659, 12'd3683, 12'd3705,
    12'd3727, 12'd3747,
    12'd3767, 12'd3785, 12'd3803, 12'd3819, 12'd3835, 12'd3850, 12'd3864, 12'd3877,
    12'd3890, 12'd3902,
    12'd3913, 12'd3924, 12'd3934, 12'd3943, 12'd3952, 12'd3960, 12'd3968, 12'd3976,
    12'd3983, 12'd3990,
    12'd3996, 12'd4002, 12'd4007, 12'd4013, 12'd4018, 12'd4022, 12'd4027, 12'd4031,
    12'd4035, 12'd4038,
    12'd4042, 12'd4045, 12'd4048, 12'd4051, 12'd4054, 12'd4056, 12'd4059, 12'd4061,
    12'd4063, 12'd4065,
    12'd4067, 12'd4069, 12'd4070, 12'd4072, 12'd4073, 12'd4075, 12'd4076, 12'd4077,
    12'd4078, 12'd4079,
    12'd4080, 12'd4081, 12'd4082, 12'd4083, 12'd4084, 12'd4085, 12'd4085, 12'd4086,
    12'd4086, 12'd4087,
    12'd4088, 12'd4088, 12'd4089, 12'd4089, 12'd4089, 12'd4090, 12'd4090, 12'd4091,
    12'd4091, 12'd4091,
    12'd4091, 12'd4092, 12'd4092, 12'd4092, 12'd4092, 12'd4093, 12'd4093, 12'd4093,
    12'd4093, 12'd4093,
    12'd4094, 12'd4094, 12'd4094, 12'd4094, 12'd4094, 12'd4094, 12'd4094, 12'd4094,
    12'd4095
  };

  // saturate a floor-shifted Q4.12 value to 16 bits
  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [ACC_W-FRAC_W-1:0] v);
    logic signed [ACC_W-FRAC_W-1:0] hi;
    logic signed [ACC_W-FRAC_W-1:0] lo;
    hi = (ACC_W-FRAC_W)'(32767);
    lo = -(ACC_W-FRAC_W)'(32768);
    if (v > hi) sat16 = 16'sh7FFF;
    else if (v < lo) sat16 = 16'sh8000;
    else sat16 = v[VAL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/nws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nws_front - input side of the neuron evaluator
// Takes (value, weight) items, forms the Q8.24 product and queues it with
// its end-of-run mark.
// ----------------------------------------------------------------------------
module nws_front import nws_pkg::*; #(
  parameter int QUEUE_DEPTH = NWS_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] link_weight,
  input  logic                    last_link,
  output logic                    q_valid,
  output q_entry_t                q_head,
  input  logic                    q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  q_entry_t        wr_entry;

  assign in_stall = (count == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_head   = mem[rd_ptr];

  always_comb begin
    // sign-extend both operands so the full Q8.24 product is kept
    wr_entry.prod = PROD_W'(in_value) * PROD_W'(link_weight);
    wr_entry.last = last_link;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/nws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nws_back - accumulator of the neuron evaluator
// Drains queued products into a saturating 40-bit sum, keeps the first
// product of the run and hands both over at the end of a run.
// ----------------------------------------------------------------------------
module nws_back import nws_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     q_pop,
  output logic     fin_valid,
  output fin_t     fin,
  input  logic     fin_take
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0]  sum_acc;
  logic signed [PROD_W-1:0] first_product;
  logic                     at_first;
  logic signed [ACC_W:0]    sum_wide;
  logic signed [ACC_W-1:0]  sum_next;
  logic signed [PROD_W-1:0] first_next;

  // a last product waits only while the previous total is still parked
  assign q_pop = q_valid && (!q_head.last || !fin_valid || fin_take);

  always_comb begin
    sum_wide = {sum_acc[ACC_W-1], sum_acc}
             + {{(ACC_W+1-PROD_W){q_head.prod[PROD_W-1]}}, q_head.prod};
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_next = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_next = sum_wide[ACC_W-1:0];
    end
    first_next = at_first ? q_head.prod : first_product;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      fin.sum   <= sum_next;
      fin.first <= first_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc       <= '0;
      first_product <= '0;
      at_first      <= 1'b1;
      fin_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_head.last) begin
          sum_acc       <= '0;
          first_product <= '0;
          at_first      <= 1'b1;
        end else begin
          sum_acc       <= sum_next;
          first_product <= first_next;
          at_first      <= 1'b0;
        end
      end
      if (q_pop && q_head.last) fin_valid <= 1'b1;
      else if (fin_take) fin_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/nws_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nws_out - output stage of the neuron evaluator
// Picks the linear or sigmoid activation and holds it in the output register.
// ----------------------------------------------------------------------------
module nws_out import nws_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     input_layer_mode,
  input  logic                     fin_valid,
  input  fin_t                     fin,
  output logic                     fin_take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  activation
);

  localparam int SHW = ACC_W - FRAC_W;

  logic signed [SHW-1:0]    lin_shr;
  logic signed [SHW-1:0]    sum_shr;
  logic signed [VAL_W-1:0]  lin_sat;
  logic signed [VAL_W-1:0]  sum_sat;
  logic [SIG_IDX_W-1:0]     sig_idx;
  logic signed [VAL_W-1:0]  act_next;

  assign fin_take = fin_valid && (!out_valid || !out_stall);

  always_comb begin
    lin_shr = SHW'(fin.first >>> FRAC_W);
    sum_shr = fin.sum[ACC_W-1:FRAC_W];
    lin_sat = sat16(lin_shr);
    sum_sat = sat16(sum_shr);
    // offset by half range: flip the sign bit, keep the top bits
    sig_idx = {~sum_sat[VAL_W-1], sum_sat[VAL_W-2:VAL_W-SIG_IDX_W]};
    if (input_layer_mode) begin
      act_next = lin_sat;
    end else begin
      act_next = {{(VAL_W-SIG_W){1'b0}}, SIG_TABLE[sig_idx]};
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      activation <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (fin_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/neuron_weighted_sum_sigmoid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neuron_weighted_sum_sigmoid - single-neuron multiply-accumulate evaluator
// Sums Q4.12 (value, weight) products of one run and emits sigmoid(sum), or
// in input-layer mode the saturated first product.
// ----------------------------------------------------------------------------
// Usage: stream one (in_value, link_weight) item per clock and set last_link
// on the final item of each neuron; a bias is just an item with value 1.0
// (4096). While the output is not stalled, the block takes one item every
// cycle with no gaps, also across run boundaries: the front multiplies each
// item and pushes the product into a QUEUE_DEPTH-entry queue, the back drains
// one product per cycle into a saturating 40-bit accumulator, and a final
// stage does the table lookup or linear select into the output register. One
// activation item comes out per run: out_valid rises once the run's result has
// passed the queue and the parked total into the output register, when none
// of these stalls. With the output stalled, one result sits in the output
// register and one finished total parks in the back; products of the next run
// still drain into the accumulator, and only once that run's last product
// reaches the queue head does the queue fill and in_stall rise.
// input_layer_mode must only be written while no run is in flight.
// ----------------------------------------------------------------------------
module neuron_weighted_sum_sigmoid import nws_pkg::*; #(
  parameter int QUEUE_DEPTH = NWS_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] link_weight,
  input  logic                    last_link,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] activation
);

  logic     input_layer_mode;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;
  logic     fin_valid;
  logic     fin_take;
  fin_t     fin;

  // mode register, 0 = sigmoid of sum, 1 = linear first product
  always_ff @(posedge clk) begin
    if (rst) begin
      input_layer_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      input_layer_mode <= cfg_wr_data;
    end
  end

  // front: accept, multiply, queue
  nws_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .link_weight (link_weight),
    .last_link   (last_link),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  // back: accumulate until end of run
  nws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_take  (fin_take)
  );

  // activation select and output register
  nws_out u_out (
    .clk              (clk),
    .rst              (rst),
    .input_layer_mode (input_layer_mode),
    .fin_valid        (fin_valid),
    .fin              (fin),
    .fin_take         (fin_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .activation       (activation)
  );

  // the back never drains an empty queue
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a finished total stays parked until the output stage takes it
  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !fin_take |=> fin_valid)
    else $error("parked total dropped");

  // an end of run never overwrites a total still waiting
  a_no_fin_overwrite: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.last && fin_valid |-> fin_take)
    else $error("parked total overwritten");

endmodule
